// ===== src/srps_pkg.sv =====
package srps_pkg;

  // Field and register widths
  localparam int unsigned ADDR_W    = 16;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned VALUE_W   = 16;
  localparam int unsigned STAGE_W   = 4;
  localparam int unsigned SLOT_W    = 3;
  localparam int unsigned POS_OUT_W = 5;
  localparam int unsigned CFG_IDX_W = 4;
  localparam int unsigned NUM_REGS  = 8;
  localparam int unsigned REG_SEL_W = 3;

  // Poll stages
  localparam logic [STAGE_W-1:0] STAGE_PASSIVE   = 4'd0;
  localparam logic [STAGE_W-1:0] STAGE_ANNOUNCE  = 4'd1;
  localparam logic [STAGE_W-1:0] STAGE_CMD_FIRST = 4'd2;

  // Reset values of the slot addresses, slot 7 leftmost
  localparam logic [NUM_REGS-1:0][ADDR_W-1:0] SLOT_ADDR_RESET = {
    16'd999, 16'd106, 16'd28, 16'd22, 16'd16, 16'd12, 16'd9, 16'd0
  };

  // Transmit frame bytes
  localparam logic [BYTE_W-1:0] TX_IDLE     = 8'hFF;
  localparam logic [BYTE_W-1:0] TX_ANNOUNCE = 8'hF9;

  // Request layout, byte 0 rightmost; address and CRC places hold zero
  localparam int unsigned REQ_LEN   = 14;
  localparam int unsigned REQ_IDX_W = 4;
  localparam logic [REQ_IDX_W-1:0] REQ_POS_ADDR_HI = 4'd7;
  localparam logic [REQ_IDX_W-1:0] REQ_POS_ADDR_LO = 4'd8;
  localparam logic [REQ_IDX_W-1:0] REQ_POS_CRC_LO  = 4'd11;
  localparam logic [REQ_IDX_W-1:0] REQ_POS_CRC_HI  = 4'd12;
  localparam logic [REQ_LEN-1:0][BYTE_W-1:0] REQ_TEMPLATE = {
    8'h55, 8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 8'h00,
    8'h03, 8'hFF, 8'h08, 8'hFA, 8'h00, 8'h0C, 8'h06
  };

  // Fixed bytes covered by the CRC around the address
  localparam logic [BYTE_W-1:0] MB_UNIT_ID  = 8'hFF;
  localparam logic [BYTE_W-1:0] MB_FC_READ  = 8'h03;
  localparam logic [BYTE_W-1:0] MB_COUNT_HI = 8'h00;
  localparam logic [BYTE_W-1:0] MB_COUNT_LO = 8'h01;
  localparam logic [15:0]       CRC_INIT    = 16'hFFFF;
  localparam logic [15:0]       CRC_POLY    = 16'hA001;

  // Context of the frame being emitted
  typedef struct packed {
    logic [STAGE_W-1:0] stage;
    logic [ADDR_W-1:0]  addr;
    logic [15:0]        crc;
  } frame_ctx_t;

  // One byte of the reflected CRC
  function automatic logic [15:0] crc_byte(logic [15:0] crc, logic [BYTE_W-1:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  // CRC of the request with a zero address
  function automatic logic [15:0] crc_base();
    logic [15:0] c;
    c = crc_byte(CRC_INIT, MB_UNIT_ID);
    c = crc_byte(c, MB_FC_READ);
    c = crc_byte(c, 8'h00);
    c = crc_byte(c, 8'h00);
    c = crc_byte(c, MB_COUNT_HI);
    c = crc_byte(c, MB_COUNT_LO);
    return c;
  endfunction

  // Contribution of each address bit; the CRC is linear in the data
  function automatic logic [ADDR_W-1:0][15:0] crc_cols();
    logic [ADDR_W-1:0][15:0] cols;
    logic [15:0]             c;
    logic [ADDR_W-1:0]       a;
    for (int j = 0; j < ADDR_W; j++) begin
      a       = ADDR_W'(1) << j;
      c       = crc_byte(16'h0000, a[15:8]);
      c       = crc_byte(c, a[7:0]);
      c       = crc_byte(c, 8'h00);
      c       = crc_byte(c, 8'h00);
      cols[j] = c;
    end
    return cols;
  endfunction

  localparam logic [15:0]             CRC_BASE = crc_base();
  localparam logic [ADDR_W-1:0][15:0] CRC_COLS = crc_cols();

  // CRC of the read request for one address
  function automatic logic [15:0] crc_for_addr(logic [ADDR_W-1:0] addr);
    logic [15:0] c;
    c = CRC_BASE;
    for (int j = 0; j < ADDR_W; j++) begin
      if (addr[j]) begin
        c = c ^ CRC_COLS[j];
      end
    end
    return c;
  endfunction

endpackage

// ===== src/srps_tx_byte.sv =====
module srps_tx_byte #(
  parameter int unsigned CNT_W = 5
) (
  input  srps_pkg::frame_ctx_t         ctx_i,
  input  logic [CNT_W-1:0]             pos_i,
  output logic [srps_pkg::BYTE_W-1:0]  tx_byte_o
);
  import srps_pkg::*;

  logic [REQ_IDX_W-1:0] req_idx;
  logic [BYTE_W-1:0]    req_byte;
  logic                 in_req;

  assign req_idx = pos_i[REQ_IDX_W-1:0];
  assign in_req  = (pos_i < CNT_W'(REQ_LEN));

  // Pick the request byte, filling in address and CRC
  always_comb begin
    req_byte = REQ_TEMPLATE[req_idx];
    if (req_idx == REQ_POS_ADDR_HI) begin
      req_byte = ctx_i.addr[15:8];
    end else if (req_idx == REQ_POS_ADDR_LO) begin
      req_byte = ctx_i.addr[7:0];
    end else if (req_idx == REQ_POS_CRC_LO) begin
      req_byte = ctx_i.crc[7:0];
    end else if (req_idx == REQ_POS_CRC_HI) begin
      req_byte = ctx_i.crc[15:8];
    end
  end

  // Choose the frame byte by stage; the request goes out inverted
  always_comb begin
    tx_byte_o = TX_IDLE;
    if (ctx_i.stage == STAGE_ANNOUNCE) begin
      if (pos_i == '0) begin
        tx_byte_o = TX_ANNOUNCE;
      end
    end else if (ctx_i.stage >= STAGE_CMD_FIRST) begin
      if (in_req) begin
        tx_byte_o = ~req_byte;
      end
    end
  end

endmodule

// ===== src/spi_register_poll_sequencer_core.sv =====
// Each accepted item yields FRAME_BYTES result items, one per cycle while the output
// is not stalled. The first result item passes through the frame registers, then the output register.
// A new input item is taken only when idle or once the current frame is done: in the
// cycle that the last byte of the current frame is loaded, set by the byte counter.
// Reset: stage returns to passive, slot addresses return to their defaults,
// no frame in flight and no result item pending.
module spi_register_poll_sequencer_core #(
  parameter int unsigned NUM_SLOTS   = 8,
  parameter int unsigned FRAME_BYTES = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [srps_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [srps_pkg::ADDR_W-1:0]    cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [srps_pkg::BYTE_W-1:0]    resp_high_i,
  input  logic [srps_pkg::BYTE_W-1:0]    resp_low_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [srps_pkg::BYTE_W-1:0]    tx_byte_o,
  output logic [srps_pkg::POS_OUT_W-1:0] byte_position_o,
  output logic                           frame_end_o,
  output logic                           value_valid_o,
  output logic [srps_pkg::SLOT_W-1:0]    value_slot_o,
  output logic [srps_pkg::VALUE_W-1:0]   captured_value_o
);
  import srps_pkg::*;

  localparam int unsigned CNT_W =
    ($clog2(FRAME_BYTES) > POS_OUT_W) ? $clog2(FRAME_BYTES) : POS_OUT_W;
  localparam logic [CNT_W-1:0]   POS_LAST   = CNT_W'(FRAME_BYTES - 1);
  localparam logic [STAGE_W-1:0] STAGE_LAST = STAGE_W'(NUM_SLOTS + 1);

  logic [NUM_REGS-1:0][ADDR_W-1:0] slot_addr_q;
  logic [STAGE_W-1:0]              stage_q, stage_d;

  logic                  gen_active_q, gen_active_d;
  logic [CNT_W-1:0]      gen_pos_q, gen_pos_d;
  frame_ctx_t            gen_ctx_q, gen_ctx_d;
  logic                  gen_vvalid_q, gen_vvalid_d;
  logic [SLOT_W-1:0]     gen_slot_q, gen_slot_d;
  logic [VALUE_W-1:0]    gen_value_q, gen_value_d;

  logic                  out_valid_q, out_valid_d;
  logic [BYTE_W-1:0]     out_byte_q;
  logic [POS_OUT_W-1:0]  out_pos_q;
  logic                  out_end_q;
  logic                  out_vvalid_q;
  logic [SLOT_W-1:0]     out_slot_q;
  logic [VALUE_W-1:0]    out_value_q;

  logic                  in_accept;
  logic                  out_load;
  logic                  gen_last;
  logic [STAGE_W-1:0]    next_stage;
  logic [REG_SEL_W-1:0]  next_sel;
  logic [ADDR_W-1:0]     next_addr;
  logic                  cur_cmd;
  logic [BYTE_W-1:0]     gen_byte;

  assign cfg_ready_o = 1'b1;

  // Load a result item while a frame is active and the output register is free or being drained
  assign out_load   = gen_active_q && (!out_valid_q || out_ready_i);
  assign gen_last   = (gen_pos_q == POS_LAST);
  assign in_ready_o = !gen_active_q || (out_load && gen_last);
  assign in_accept  = in_valid_i && in_ready_o;

  // Advance the stage and look up the address of the next command
  assign cur_cmd    = (stage_q >= STAGE_CMD_FIRST);
  assign next_stage = (stage_q >= STAGE_LAST) ? STAGE_PASSIVE : stage_q + STAGE_W'(1);
  assign next_sel   = REG_SEL_W'(next_stage - STAGE_CMD_FIRST);
  assign next_addr  = slot_addr_q[next_sel];

  // Hold the slot addresses; drop writes beyond the register list
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_addr_q <= SLOT_ADDR_RESET;
    end else if (cfg_valid_i && cfg_ready_o && (cfg_index_i < CFG_IDX_W'(NUM_REGS))) begin
      slot_addr_q[cfg_index_i[REG_SEL_W-1:0]] <= cfg_data_i;
    end
  end

  // Capture a new item or step through the frame
  always_comb begin
    stage_d      = stage_q;
    gen_active_d = gen_active_q;
    gen_pos_d    = gen_pos_q;
    gen_ctx_d    = gen_ctx_q;
    gen_vvalid_d = gen_vvalid_q;
    gen_slot_d   = gen_slot_q;
    gen_value_d  = gen_value_q;
    if (in_accept) begin
      stage_d         = next_stage;
      gen_active_d    = 1'b1;
      gen_pos_d       = '0;
      gen_ctx_d.stage = next_stage;
      gen_ctx_d.addr  = next_addr;
      gen_ctx_d.crc   = crc_for_addr(next_addr);
      gen_vvalid_d    = cur_cmd;
      gen_slot_d      = cur_cmd ? SLOT_W'(stage_q - STAGE_CMD_FIRST) : '0;
      gen_value_d     = cur_cmd ? {resp_high_i, resp_low_i} : '0;
    end else if (out_load) begin
      if (gen_last) begin
        gen_active_d = 1'b0;
      end else begin
        gen_pos_d = gen_pos_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q      <= STAGE_PASSIVE;
      gen_active_q <= 1'b0;
      gen_pos_q    <= '0;
    end else begin
      stage_q      <= stage_d;
      gen_active_q <= gen_active_d;
      gen_pos_q    <= gen_pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    gen_ctx_q    <= gen_ctx_d;
    gen_vvalid_q <= gen_vvalid_d;
    gen_slot_q   <= gen_slot_d;
    gen_value_q  <= gen_value_d;
  end

  // Form the transmit byte for the current position
  srps_tx_byte #(
    .CNT_W (CNT_W)
  ) u_tx_byte (
    .ctx_i     (gen_ctx_q),
    .pos_i     (gen_pos_q),
    .tx_byte_o (gen_byte)
  );

  // Output register
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_byte_q   <= gen_byte;
      out_pos_q    <= gen_pos_q[POS_OUT_W-1:0];
      out_end_q    <= gen_last;
      out_vvalid_q <= gen_vvalid_q;
      out_slot_q   <= gen_slot_q;
      out_value_q  <= gen_value_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign tx_byte_o        = out_byte_q;
  assign byte_position_o  = out_pos_q;
  assign frame_end_o      = out_end_q;
  assign value_valid_o    = out_vvalid_q;
  assign value_slot_o     = out_slot_q;
  assign captured_value_o = out_value_q;

endmodule

// ===== tb/tb_spi_register_poll_sequencer_core.sv =====
`timescale 1ns / 100ps

module tb_spi_register_poll_sequencer_core;
  import srps_pkg::*;

  localparam int SLOTS       = 8;
  localparam int FRAME_LEN   = 32;
  localparam int DIR_ROWS    = 22;
  localparam int RETUNE_ROW  = 11;
  localparam int PHASES      = 6;
  localparam int PHASE_ITEMS = 35;
  localparam int STALL_LIMIT = 2000;
  localparam int SETTLE      = 4;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_SLOT0_ADDR  = '0;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = CFG_IDX_W'(NUM_REGS);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LAST  = '1;

  // Frame bytes and the plain read request ahead of the address, byte 0 rightmost
  localparam logic [7:0] IDLE_BYTE     = 8'hFF;
  localparam logic [7:0] ANNOUNCE_BYTE = 8'hF9;
  localparam logic [7:0] REQ_TRAILER   = 8'h55;
  localparam logic [6:0][7:0] REQ_HEAD = {
    8'h03, 8'hFF, 8'h08, 8'hFA, 8'h00, 8'h0C, 8'h06
  };
  localparam logic [7:0][15:0] ADDR_DEFAULTS = {
    16'd999, 16'd106, 16'd28, 16'd22, 16'd16, 16'd12, 16'd9, 16'd0
  };

  typedef enum {PLAN_SPLIT_HIGH, PLAN_SPLIT_LOW, PLAN_RANDOM} slot_plan_e;

  typedef struct packed {
    logic [7:0]  tx_byte;
    logic [4:0]  position;
    logic        last;
    logic        has_value;
    logic [2:0]  slot;
    logic [15:0] value;
  } tx_byte_t;

  // Directed transaction; where pinned, byte 0 and the value are typed in
  typedef struct packed {
    logic [7:0]  hi;
    logic [7:0]  lo;
    logic        pinned;
    logic [7:0]  first_byte;
    logic        has_value;
    logic [15:0] value;
  } poll_row_t;

  localparam poll_row_t DIRECTED [DIR_ROWS] = '{
    '{8'h00, 8'h00, 1'b1, 8'hF9, 1'b0, 16'h0000},
    '{8'hFF, 8'hFF, 1'b1, 8'hF9, 1'b0, 16'h0000},
    '{8'hFF, 8'hFF, 1'b1, 8'hF9, 1'b1, 16'hFFFF},
    '{8'h00, 8'h00, 1'b1, 8'hF9, 1'b1, 16'h0000},
    '{8'h80, 8'h01, 1'b0, 8'h00, 1'b0, 16'h0000},
    '{8'h01, 8'h80, 1'b0, 8'h00, 1'b0, 16'h0000},
    '{8'hAA, 8'h55, 1'b0, 8'h00, 1'b0, 16'h0000},
    '{8'h55, 8'hAA, 1'b0, 8'h00, 1'b0, 16'h0000},
    '{8'h7F, 8'hFE, 1'b0, 8'h00, 1'b0, 16'h0000},
    '{8'h12, 8'h34, 1'b1, 8'hFF, 1'b1, 16'h1234},
    '{8'hFF, 8'h00, 1'b1, 8'hF9, 1'b0, 16'h0000},
    '{8'h5A, 8'hA5, 1'b1, 8'hF9, 1'b0, 16'h0000},
    '{8'h00, 8'h00, 1'b1, 8'hF9, 1'b1, 16'h0000},
    '{8'hFF, 8'hFF, 1'b1, 8'hF9, 1'b1, 16'hFFFF},
    '{8'h00, 8'h01, 1'b0, 8'h00, 1'b0, 16'h0000},
    '{8'h80, 8'h00, 1'b0, 8'h00, 1'b0, 16'h0000},
    '{8'hFF, 8'h00, 1'b0, 8'h00, 1'b0, 16'h0000},
    '{8'h00, 8'hFF, 1'b0, 8'h00, 1'b0, 16'h0000},
    '{8'h3C, 8'hC3, 1'b0, 8'h00, 1'b0, 16'h0000},
    '{8'hBE, 8'hEF, 1'b1, 8'hFF, 1'b1, 16'hBEEF},
    '{8'h00, 8'h00, 1'b1, 8'hF9, 1'b0, 16'h0000},
    '{8'hC3, 8'h3C, 1'b1, 8'hF9, 1'b0, 16'h0000}
  };

  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_valid_i;
  logic                   cfg_ready_o;
  logic [CFG_IDX_W-1:0]   cfg_index_i;
  logic [ADDR_W-1:0]      cfg_data_i;
  logic                   in_valid_i;
  logic                   in_ready_o;
  logic [BYTE_W-1:0]      resp_high_i;
  logic [BYTE_W-1:0]      resp_low_i;
  logic                   out_valid_o;
  logic                   out_ready_i = 1'b1;
  logic [BYTE_W-1:0]      tx_byte_o;
  logic [POS_OUT_W-1:0]   byte_position_o;
  logic                   frame_end_o;
  logic                   value_valid_o;
  logic [SLOT_W-1:0]      value_slot_o;
  logic [VALUE_W-1:0]     captured_value_o;

  // Predictor state and the bytes still owed by the block
  logic [STAGE_W-1:0]     poll_stage_q;
  logic [15:0]            slot_addr_q [NUM_REGS];
  tx_byte_t               next_frame [FRAME_LEN];
  tx_byte_t               owed_bytes_q [$];

  poll_row_t              pin_row;
  logic                   pin_active;
  logic                   calm;
  int                     stall_left;
  int                     idle_cycles;
  int                     mismatches;
  int                     items_taken;
  int                     bytes_checked;
  int                     reg_writes;

  spi_register_poll_sequencer_core #(
    .NUM_SLOTS  (SLOTS),
    .FRAME_BYTES(FRAME_LEN)
  ) DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .resp_high_i     (resp_high_i),
    .resp_low_i      (resp_low_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .tx_byte_o       (tx_byte_o),
    .byte_position_o (byte_position_o),
    .frame_end_o     (frame_end_o),
    .value_valid_o   (value_valid_o),
    .value_slot_o    (value_slot_o),
    .captured_value_o(captured_value_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // CRC-16 over the six request bytes that carry the address
  function automatic logic [15:0] read_crc(input logic [15:0] addr);
    logic [5:0][7:0] msg;
    logic [15:0]     c;
    msg = {8'h01, 8'h00, addr[7:0], addr[15:8], 8'h03, 8'hFF};
    c   = 16'hFFFF;
    for (int i = 0; i < 6; i++) begin
      c = c ^ {8'h00, msg[i]};
      for (int b = 0; b < 8; b++) begin
        c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
      end
    end
    return c;
  endfunction

  // Capture the value of a command stage, advance the stage, build the next frame
  task automatic advance_poll(input logic [7:0] hi, input logic [7:0] lo);
    logic [7:0]       frame [FRAME_LEN];
    logic [13:0][7:0] req;
    logic [15:0]      addr;
    logic [15:0]      crc;
    logic             got;
    logic [2:0]       slot;
    logic [15:0]      value;
    int               nxt;
    got   = 1'b0;
    slot  = '0;
    value = '0;
    if (poll_stage_q >= STAGE_CMD_FIRST && poll_stage_q < STAGE_CMD_FIRST + SLOTS) begin
      got   = 1'b1;
      slot  = 3'(poll_stage_q - STAGE_CMD_FIRST);
      value = {hi, lo};
    end
    nxt = int'(poll_stage_q) + 1;
    if (nxt >= SLOTS + 2) begin
      nxt = 0;
    end
    poll_stage_q = STAGE_W'(nxt);
    for (int i = 0; i < FRAME_LEN; i++) begin
      frame[i] = IDLE_BYTE;
    end
    if (poll_stage_q == STAGE_ANNOUNCE) begin
      frame[0] = ANNOUNCE_BYTE;
    end else if (poll_stage_q >= STAGE_CMD_FIRST) begin
      addr = slot_addr_q[3'(poll_stage_q - STAGE_CMD_FIRST)];
      crc  = read_crc(addr);
      req  = {REQ_TRAILER, crc[15:8], crc[7:0], 8'h01, 8'h00, addr[7:0], addr[15:8],
              REQ_HEAD};
      for (int i = 0; i < 14; i++) begin
        frame[i] = ~req[i];
      end
    end
    for (int i = 0; i < FRAME_LEN; i++) begin
      next_frame[i] = '{frame[i], 5'(i), i == FRAME_LEN - 1, got, slot, value};
    end
  endtask

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    mismatches++;
    $display("%0t: %s after %0d bytes: got %0h, want %0h", $realtime, what,
             bytes_checked, got, want);
  endtask

  // Compare output bytes, follow register writes and predict for each accepted item
  always @(posedge clk_i) begin : watch_ports
    tx_byte_t want;
    logic     moved;
    if (rst_ni) begin
      moved = 1'b0;
      if (out_valid_o && out_ready_i) begin
        moved = 1'b1;
        if (owed_bytes_q.size() == 0) begin
          report_mismatch("frame byte with nothing owed", 16'(tx_byte_o), 16'h0000);
        end else begin
          want = owed_bytes_q.pop_front();
          if (tx_byte_o !== want.tx_byte)
            report_mismatch("tx_byte", 16'(tx_byte_o), 16'(want.tx_byte));
          if (byte_position_o !== want.position)
            report_mismatch("byte_position", 16'(byte_position_o), 16'(want.position));
          if (frame_end_o !== want.last)
            report_mismatch("frame_end", 16'(frame_end_o), 16'(want.last));
          if (value_valid_o !== want.has_value)
            report_mismatch("value_valid", 16'(value_valid_o), 16'(want.has_value));
          if (value_slot_o !== want.slot)
            report_mismatch("value_slot", 16'(value_slot_o), 16'(want.slot));
          if (captured_value_o !== want.value)
            report_mismatch("captured_value", captured_value_o, want.value);
        end
        bytes_checked++;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        moved = 1'b1;
        reg_writes++;
        if (cfg_index_i < NUM_REGS) begin
          slot_addr_q[cfg_index_i[REG_SEL_W-1:0]] = cfg_data_i;
        end
      end
      if (in_valid_i && in_ready_o) begin
        moved = 1'b1;
        items_taken++;
        advance_poll(resp_high_i, resp_low_i);
        // Typed-in rows take byte 0 and the value from the table
        if (pin_active && pin_row.pinned) begin
          next_frame[0].tx_byte = pin_row.first_byte;
          for (int i = 0; i < FRAME_LEN; i++) begin
            next_frame[i].has_value = pin_row.has_value;
            next_frame[i].value     = pin_row.value;
          end
        end
        for (int i = 0; i < FRAME_LEN; i++) begin
          owed_bytes_q.push_back(next_frame[i]);
        end
      end
      // Watchdog on handshakes of any channel
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("no handshake for %0d cycles, %0d bytes owed", idle_cycles,
                 owed_bytes_q.size());
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // Stall the byte stream in random bursts, never in the calm phase
  always @(negedge clk_i) begin
    if (!rst_ni || calm) begin
      out_ready_i = 1'b1;
    end else if (stall_left > 0) begin
      out_ready_i = 1'b0;
      stall_left--;
    end else begin
      out_ready_i = 1'b1;
      if ($urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 7);
      end
    end
  end

  task automatic send_transaction(input logic [7:0] hi, input logic [7:0] lo,
                                  input logic pinned, input poll_row_t row);
    int backlog;
    pin_active  = pinned;
    pin_row     = row;
    resp_high_i = hi;
    resp_low_i  = lo;
    in_valid_i  = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
    // Drop valid for a burst, at a random point of the frame being emitted
    if (!calm && $urandom_range(0, 2) == 0) begin
      in_valid_i = 1'b0;
      backlog    = $urandom_range(0, FRAME_LEN);
      while (owed_bytes_q.size() > backlog) @(negedge clk_i);
      repeat ($urandom_range(1, 7)) @(negedge clk_i);
    end
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
    cfg_index_i = idx;
    cfg_data_i  = data;
    cfg_valid_i = 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
  endtask

  // Wait until every owed byte is out and the block has settled
  task automatic drain_frames();
    in_valid_i = 1'b0;
    while (owed_bytes_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  task automatic program_slots(input slot_plan_e plan);
    logic [15:0]          data;
    logic [CFG_IDX_W-1:0] spare;
    for (int s = 0; s < NUM_REGS; s++) begin
      if (plan == PLAN_SPLIT_HIGH) begin
        data = s[0] ? 16'h0000 : 16'hFFFF;
      end else if (plan == PLAN_SPLIT_LOW) begin
        data = s[0] ? 16'hFFFF : 16'h0000;
      end else begin
        case ($urandom_range(0, 3))
          0:       data = 16'h0000;
          1:       data = 16'hFFFF;
          default: data = 16'($urandom);
        endcase
      end
      if (plan != PLAN_RANDOM || $urandom_range(0, 3) != 0) begin
        write_register(REG_SLOT0_ADDR + CFG_IDX_W'(s), data);
      end
    end
    // Spare indexes must leave the slots untouched
    if (plan == PLAN_SPLIT_HIGH) begin
      spare = REG_SPARE_FIRST;
    end else if (plan == PLAN_SPLIT_LOW) begin
      spare = REG_SPARE_LAST;
    end else begin
      spare = CFG_IDX_W'($urandom_range(NUM_REGS, 15));
    end
    write_register(spare, 16'($urandom));
    cfg_valid_i = 1'b0;
  endtask

  initial begin
    poll_row_t blank;
    blank         = '0;
    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;
    in_valid_i    = 1'b0;
    resp_high_i   = '0;
    resp_low_i    = '0;
    pin_active    = 1'b0;
    pin_row       = '0;
    calm          = 1'b0;
    stall_left    = 0;
    idle_cycles   = 0;
    mismatches    = 0;
    items_taken   = 0;
    bytes_checked = 0;
    reg_writes    = 0;
    poll_stage_q  = STAGE_PASSIVE;
    for (int i = 0; i < NUM_REGS; i++) begin
      slot_addr_q[i] = ADDR_DEFAULTS[i];
    end
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed table: one full poll cycle on reset addresses, then on split extremes
    for (int r = 0; r < DIR_ROWS; r++) begin
      if (r == RETUNE_ROW) begin
        drain_frames();
        program_slots(PLAN_SPLIT_HIGH);
      end
      send_transaction(DIRECTED[r].hi, DIRECTED[r].lo, 1'b1, DIRECTED[r]);
    end

    // Random responses, new slot addresses per phase, last phase without idling
    for (int p = 0; p < PHASES; p++) begin
      drain_frames();
      program_slots(p == 0 ? PLAN_SPLIT_LOW : PLAN_RANDOM);
      calm = (p == PHASES - 1);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        send_transaction(8'($urandom), 8'($urandom), 1'b0, blank);
      end
    end

    drain_frames();
    repeat (8) @(posedge clk_i);
    $display("%0d transactions over %0d poll stages, %0d frame bytes checked",
             items_taken, SLOTS + 2, bytes_checked);
    $display("%0d register writes incl. spare indexes, %0d mismatches",
             reg_writes, mismatches);
    if (mismatches == 0 && owed_bytes_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
